>>> rtl/stb_pkg.sv
// Shared types and constants for the subscription table broadcaster.
// No dependencies; compiled first.
`timescale 1ns / 1ps
`default_nettype none

package stb_pkg;

  localparam int CHAN_W         = 8;
  localparam int TASK_W         = 16;
  localparam int ARG_W          = 32;
  localparam int CFG_IDX_W      = 2;
  localparam int TABLE_ENTRIES_DEF = 16;

  typedef enum logic [1:0] {
    CMD_SUB    = 2'd0,
    CMD_UNSUB  = 2'd1,
    CMD_NOTIFY = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_ILLEGAL   = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  localparam logic [CFG_IDX_W-1:0] CFG_LOWEST   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HIGHEST  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WILDCARD = 2'd2;

  // Controller -> datapath commands
  typedef struct packed {
    logic    load_in;
    logic    clr_all;
    logic    scan_start;
    logic    scan_en;
    logic    drop;
    logic    sub_write;
    logic    emit_stat;
    status_t stat;
  } ctl_cmd_t;

  // Datapath -> controller status
  typedef struct packed {
    cmd_t cmd;
    logic chan_ok;
    logic stop_hit;
    logic scan_done;
    logic free_found;
    logic out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

>>> rtl/stb_ifs.sv
// Handshake channel interfaces: command input, result output, register writes.
// Depends on stb_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface stb_in_if;
  import stb_pkg::*;
  logic                valid;
  logic                ready;
  logic [1:0]          cmd;
  logic [CHAN_W-1:0]   channel_number;
  logic [TASK_W-1:0]   task_handle;
  logic [ARG_W-1:0]    notify_argument;

  modport source (output valid, cmd, channel_number, task_handle, notify_argument,
                  input ready);
  modport sink   (input valid, cmd, channel_number, task_handle, notify_argument,
                  output ready);
endinterface

interface stb_out_if;
  import stb_pkg::*;
  logic                valid;
  logic                ready;
  logic [1:0]          status;
  logic                is_call;
  logic [TASK_W-1:0]   called_task;
  logic [ARG_W-1:0]    call_argument;
  logic                last_result;

  modport source (output valid, status, is_call, called_task, call_argument, last_result,
                  input ready);
  modport sink   (input valid, status, is_call, called_task, call_argument, last_result,
                  output ready);
endinterface

interface stb_cfg_if;
  import stb_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CHAN_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> rtl/stb_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module stb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                               clk,
  input  wire logic                               we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                   wdata,
  input  wire logic                               re,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                   rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

`default_nettype wire

>>> rtl/stb_ctrl.sv
// Sequencing FSM: accept, channel check, table scan, final status beat.
// Depends on stb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module stb_ctrl
  import stb_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire dp_stat_t dp,
  output ctl_cmd_t      ctl
);

  typedef enum logic [1:0] {S_IDLE, S_START, S_SCAN, S_EMIT} state_t;

  state_t  state_r, state_nxt;
  status_t st_r, st_nxt;

  always_comb begin
    state_nxt      = state_r;
    st_nxt         = st_r;
    ctl            = '0;
    ctl.stat       = st_r;
    in_ready       = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctl.load_in = 1'b1;
          state_nxt   = S_START;
        end
      end
      S_START: begin
        if (dp.cmd == CMD_CLEAR) begin
          ctl.clr_all = 1'b1;
          st_nxt      = ST_OK;
          state_nxt   = S_EMIT;
        end else if ((dp.cmd == CMD_SUB || dp.cmd == CMD_NOTIFY) && !dp.chan_ok) begin
          st_nxt    = ST_ILLEGAL;
          state_nxt = S_EMIT;
        end else begin
          ctl.scan_start = 1'b1;
          state_nxt      = S_SCAN;
        end
      end
      S_SCAN: begin
        ctl.scan_en = 1'b1;
        if (dp.stop_hit) begin
          // duplicate subscribe or matching unsubscribe ends the scan
          ctl.drop  = (dp.cmd == CMD_UNSUB);
          st_nxt    = ST_OK;
          state_nxt = S_EMIT;
        end else if (dp.scan_done) begin
          state_nxt = S_EMIT;
          case (dp.cmd)
            CMD_SUB: begin
              ctl.sub_write = dp.free_found;
              st_nxt        = dp.free_found ? ST_OK : ST_FULL;
            end
            CMD_UNSUB: st_nxt = ST_NOT_FOUND;
            default:   st_nxt = ST_OK;
          endcase
        end
      end
      S_EMIT: begin
        if (dp.out_free) begin
          ctl.emit_stat = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      st_r    <= ST_OK;
    end else begin
      state_r <= state_nxt;
      st_r    <= st_nxt;
    end
  end

endmodule

`default_nettype wire

>>> rtl/stb_dp.sv
// Datapath: channel registers, entry RAM with valid bits, scan pipeline, result register.
// Depends on stb_pkg and stb_ram.
`timescale 1ns / 1ps
`default_nettype none

module stb_dp
  import stb_pkg::*;
#(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire ctl_cmd_t             ctl,
  output dp_stat_t                  dp,
  input  wire logic [1:0]           in_cmd,
  input  wire logic [CHAN_W-1:0]    in_channel,
  input  wire logic [TASK_W-1:0]    in_task,
  input  wire logic [ARG_W-1:0]     in_arg,
  input  wire logic                 cfg_valid,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CHAN_W-1:0]    cfg_data,
  input  wire logic                 out_ready,
  output logic                      out_valid,
  output logic [1:0]                out_status,
  output logic                      out_is_call,
  output logic [TASK_W-1:0]         out_task,
  output logic [ARG_W-1:0]          out_arg,
  output logic                      out_last
);

  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam int ENT_W = CHAN_W + TASK_W;
  localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(TABLE_ENTRIES);

  // config registers
  logic [CHAN_W-1:0] lo_r, hi_r, wild_r;

  // latched item
  cmd_t              cmd_r;
  logic [CHAN_W-1:0] ch_r;
  logic [TASK_W-1:0] task_r;
  logic [ARG_W-1:0]  arg_r;

  // table state
  logic [TABLE_ENTRIES-1:0] asg_r;
  logic [ENT_W-1:0]         ent_q;

  // scan pipeline
  logic [CNT_W-1:0] ix_r;
  logic             chk_v_r;
  logic [IDX_W-1:0] chk_idx_r;
  logic             free_v_r;
  logic [IDX_W-1:0] free_idx_r;

  // result register
  logic              out_v_r;
  status_t           out_st_r;
  logic              out_call_r;
  logic [TASK_W-1:0] out_task_r;
  logic [ARG_W-1:0]  out_arg_r;
  logic              out_last_r;

  logic [CHAN_W-1:0] ent_ch;
  logic [TASK_W-1:0] ent_task;
  logic ent_asg, ch_hit, sub_dup, eff_free, unsub_hit, call_hit;
  logic chk, out_free, stall, adv, rd_en, emit_call, more;

  assign ent_ch   = ent_q[ENT_W-1:TASK_W];
  assign ent_task = ent_q[TASK_W-1:0];
  assign ent_asg  = asg_r[chk_idx_r];

  assign ch_hit    = ent_asg && (ch_r == wild_r || ent_ch == ch_r);
  assign sub_dup   = ent_asg && ent_ch == ch_r && ent_task == task_r;
  assign eff_free  = !ent_asg || ent_task == '0;
  assign unsub_hit = ch_hit && ent_task == task_r;
  assign call_hit  = ch_hit && ent_task != '0;

  assign chk       = ctl.scan_en && chk_v_r;
  assign out_free  = !out_v_r || out_ready;
  assign emit_call = chk && cmd_r == CMD_NOTIFY && call_hit && out_free;
  assign stall     = chk && cmd_r == CMD_NOTIFY && call_hit && !out_free;
  assign adv       = ctl.scan_en && !stall;
  assign more      = ix_r < LAST_CNT;
  assign rd_en     = adv && more;

  assign dp.cmd        = cmd_r;
  assign dp.chan_ok    = (ch_r >= lo_r) && (ch_r <= hi_r);
  assign dp.stop_hit   = chk && ((cmd_r == CMD_SUB && sub_dup) ||
                                 (cmd_r == CMD_UNSUB && unsub_hit));
  assign dp.scan_done  = (ix_r == LAST_CNT) && !chk_v_r;
  assign dp.free_found = free_v_r;
  assign dp.out_free   = out_free;

  stb_ram #(
    .WIDTH (ENT_W),
    .DEPTH (TABLE_ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (ctl.sub_write),
    .waddr (free_idx_r),
    .wdata ({ch_r, task_r}),
    .re    (rd_en),
    .raddr (ix_r[IDX_W-1:0]),
    .rdata (ent_q)
  );

  // config and item latch
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lo_r   <= '0;
      hi_r   <= '1;
      wild_r <= '1;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_LOWEST:   lo_r   <= cfg_data;
        CFG_HIGHEST:  hi_r   <= cfg_data;
        CFG_WILDCARD: wild_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_in) begin
      cmd_r  <= cmd_t'(in_cmd);
      ch_r   <= in_channel;
      task_r <= in_task;
      arg_r  <= in_arg;
    end
  end

  // assigned bits
  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clr_all) begin
      asg_r <= '0;
    end else if (ctl.drop) begin
      asg_r[chk_idx_r] <= 1'b0;
    end else if (ctl.sub_write) begin
      asg_r[free_idx_r] <= 1'b1;
    end
  end

  // scan counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ix_r     <= '0;
      chk_v_r  <= 1'b0;
      free_v_r <= 1'b0;
    end else if (ctl.scan_start) begin
      ix_r     <= '0;
      chk_v_r  <= 1'b0;
      free_v_r <= 1'b0;
    end else begin
      if (adv) begin
        chk_v_r <= more;
        if (more) begin
          chk_idx_r <= ix_r[IDX_W-1:0];
          ix_r      <= ix_r + 1'b1;
        end
      end
      if (chk && !free_v_r && eff_free) begin
        free_v_r   <= 1'b1;
        free_idx_r <= chk_idx_r;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (emit_call || ctl.emit_stat) begin
      out_v_r <= 1'b1;
    end else if (out_ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_call) begin
      out_st_r   <= ST_OK;
      out_call_r <= 1'b1;
      out_task_r <= ent_task;
      out_arg_r  <= arg_r;
      out_last_r <= 1'b0;
    end else if (ctl.emit_stat) begin
      out_st_r   <= ctl.stat;
      out_call_r <= 1'b0;
      out_task_r <= '0;
      out_arg_r  <= '0;
      out_last_r <= 1'b1;
    end
  end

  assign out_valid   = out_v_r;
  assign out_status  = out_st_r;
  assign out_is_call = out_call_r;
  assign out_task    = out_task_r;
  assign out_arg     = out_arg_r;
  assign out_last    = out_last_r;

endmodule

`default_nettype wire

>>> rtl/subscription_table_broadcaster.sv
// Top level of the subscription table broadcaster: channels, controller, datapath.
// Depends on stb_pkg, stb_ifs, stb_ram, stb_ctrl and stb_dp.
`timescale 1ns / 1ps
`default_nettype none

// Publish/subscribe registry. The table holds TABLE_ENTRIES entries of (channel, task),
// kept in a small RAM with one assigned bit per entry in flops, so reset and the clear
// command empty the table at once with no sweep. One command is worked at a time: after
// an input beat is taken, the block checks a subscribe or notify channel against the
// configured range, then walks the table one entry per cycle through the single RAM
// read port. A subscribe that finds its duplicate or an unsubscribe that finds its match
// ends the walk early; clear and a rejected channel skip it. Notify emits one call beat
// per matching non-null entry, in table order, and every command ends with one status
// beat marked last_result. The output register lets the next command be taken while the
// final beat still waits; a stalled output holds the scan in place. Register writes are
// taken in any cycle, but are meant to be issued only while the block is idle.

module subscription_table_broadcaster
  import stb_pkg::*;
#(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
  input wire logic   clk,
  input wire logic   rst_n,
  stb_cfg_if.sink    cfg_ch,
  stb_in_if.sink     in_ch,
  stb_out_if.source  out_ch
);

  ctl_cmd_t ctl;
  dp_stat_t dp;

  // register writes never back-pressure
  assign cfg_ch.ready = 1'b1;

  stb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .dp       (dp),
    .ctl      (ctl)
  );

  stb_dp #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctl         (ctl),
    .dp          (dp),
    .in_cmd      (in_ch.cmd),
    .in_channel  (in_ch.channel_number),
    .in_task     (in_ch.task_handle),
    .in_arg      (in_ch.notify_argument),
    .cfg_valid   (cfg_ch.valid),
    .cfg_index   (cfg_ch.index),
    .cfg_data    (cfg_ch.data),
    .out_ready   (out_ch.ready),
    .out_valid   (out_ch.valid),
    .out_status  (out_ch.status),
    .out_is_call (out_ch.is_call),
    .out_task    (out_ch.called_task),
    .out_arg     (out_ch.call_argument),
    .out_last    (out_ch.last_result)
  );

  // one command in flight: ready drops right after a beat is taken
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("input taken while a command is in flight");

  // a new entry is written only into a free slot found by the scan
  a_write_has_slot: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.sub_write |-> dp.free_found)
    else $error("subscribe write without a free entry");

  // status beat never overwrites a result still waiting
  a_status_room: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.emit_stat |-> dp.out_free)
    else $error("status beat loaded over a pending result");

  // an entry is dropped only on an unsubscribe match
  a_drop_on_match: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.drop |-> dp.stop_hit && dp.cmd == CMD_UNSUB)
    else $error("entry dropped without a matching unsubscribe");

endmodule

`default_nettype wire

>>> sim/tb_subscription_table_broadcaster.sv
// Testbench for subscription_table_broadcaster: directed and randomized command streams,
// every result beat checked against an in-bench model of the subscriber table.
// Depends on stb_pkg, stb_ifs (stb_in_if, stb_out_if, stb_cfg_if) and the block's RTL.
`timescale 1ns / 1ps

module tb_subscription_table_broadcaster;
  import stb_pkg::*;

  localparam int ENTRIES        = 16;
  localparam int MAX_GAP        = 18;
  localparam int RX_HOLD_CYCLES = 400;
  // slowest legal run: ~450 items of up to 17 beats each, plus one long hold
  localparam int MAX_CYCLES     = 900000;

  typedef struct {
    status_t           status;
    logic              is_call;
    logic [TASK_W-1:0] called_task;
    logic [ARG_W-1:0]  call_argument;
    logic              last_result;
  } result_beat_t;

  logic clk;
  logic rst_n;

  stb_in_if  in_ch();
  stb_out_if out_ch();
  stb_cfg_if cfg_ch();

  subscription_table_broadcaster #(.TABLE_ENTRIES(ENTRIES)) DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Shadow copy of the subscriber table and the three channel registers
  logic              slot_used [ENTRIES];
  logic [CHAN_W-1:0] slot_chan [ENTRIES];
  logic [TASK_W-1:0] slot_hdl  [ENTRIES];
  logic [CHAN_W-1:0] chan_lo;
  logic [CHAN_W-1:0] chan_hi;
  logic [CHAN_W-1:0] chan_wild;

  result_beat_t owed_results[$];   // beats the block still has to deliver, oldest first
  int error_count = 0;
  int cycle_count = 0;
  int hold_seq    = 0;             // bumped to ask the receiver for one long hold-off
  bit tx_steady   = 1'b0;          // sender offers back to back when set
  bit rx_steady   = 1'b0;          // receiver takes every beat at once when set

  // 12 ns clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Watchdog: a hung handshake ends the run here
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > MAX_CYCLES) begin
      $display("%0t: timeout after %0d cycles, %0d beats still owed", $time, cycle_count,
               owed_results.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------------------
  // Table model
  // ---------------------------------------------------------------------------------------

  function automatic void drop_slot(int i);
    slot_used[i] = 1'b0;
    slot_chan[i] = '0;
    slot_hdl[i]  = '0;
  endfunction

  function automatic bit chan_in_range(logic [CHAN_W-1:0] ch);
    return (ch >= chan_lo) && (ch <= chan_hi);
  endfunction

  // wildcard hits every assigned entry; an unassigned entry never hits
  function automatic bit slot_hits(int i, logic [CHAN_W-1:0] ch);
    return slot_used[i] && ((ch == chan_wild) || (slot_chan[i] == ch));
  endfunction

  // Apply one command to the shadow table and queue the beats it must produce
  task automatic predict_command(cmd_t op, logic [CHAN_W-1:0] ch, logic [TASK_W-1:0] hdl,
                                 logic [ARG_W-1:0] arg);
    status_t st;
    int      free_slot;
    bit      dup;
    st = ST_OK;
    case (op)
      CMD_SUB: begin
        if (!chan_in_range(ch)) begin
          st = ST_ILLEGAL;
        end else begin
          free_slot = -1;
          dup = 1'b0;
          for (int i = 0; i < ENTRIES; i++) begin
            if (!dup) begin
              if (slot_used[i] && slot_chan[i] == ch && slot_hdl[i] == hdl) dup = 1'b1;
              else if (free_slot < 0 && slot_hdl[i] == '0) free_slot = i;
            end
          end
          // an existing pair wins over a full table
          if (!dup) begin
            if (free_slot < 0) begin
              st = ST_FULL;
            end else begin
              slot_used[free_slot] = 1'b1;
              slot_chan[free_slot] = ch;
              slot_hdl[free_slot]  = hdl;
            end
          end
        end
      end
      CMD_UNSUB: begin
        // channel range is not checked here; only the first match goes
        st = ST_NOT_FOUND;
        for (int i = 0; i < ENTRIES; i++) begin
          if (st == ST_NOT_FOUND && slot_hdl[i] == hdl && slot_hits(i, ch)) begin
            drop_slot(i);
            st = ST_OK;
          end
        end
      end
      CMD_NOTIFY: begin
        if (!chan_in_range(ch)) begin
          st = ST_ILLEGAL;
        end else begin
          // null-task entries are skipped
          for (int i = 0; i < ENTRIES; i++)
            if (slot_hits(i, ch) && slot_hdl[i] != '0)
              owed_results.push_back('{ST_OK, 1'b1, slot_hdl[i], arg, 1'b0});
        end
      end
      default: begin
        for (int i = 0; i < ENTRIES; i++) drop_slot(i);
      end
    endcase
    owed_results.push_back('{st, 1'b0, '0, '0, 1'b1});
  endtask

  // ---------------------------------------------------------------------------------------
  // Result side: receiver with random stalls, and the beat checker
  // ---------------------------------------------------------------------------------------

  initial begin : result_sink
    int unsigned gap;
    int          seen_hold;
    seen_hold = 0;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_seq != seen_hold) begin
        seen_hold = hold_seq;
        out_ch.ready <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(posedge clk);
      end
      gap = rx_steady ? 0 : $urandom_range(0, MAX_GAP);
      if (gap != 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!(out_ch.valid === 1'b1 && out_ch.ready === 1'b1)) @(posedge clk);
    end
  end

  task automatic compare_field(string name, logic [ARG_W-1:0] want, logic [ARG_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk) begin : result_check
    result_beat_t want;
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (owed_results.size() == 0) begin
        $display("%0t: unexpected beat, expected none, actual status=%0d call=%b task=%h arg=%h last=%b",
                 $time, out_ch.status, out_ch.is_call, out_ch.called_task,
                 out_ch.call_argument, out_ch.last_result);
        error_count++;
      end else begin
        want = owed_results.pop_front();
        compare_field("status",        want.status,        out_ch.status);
        compare_field("is_call",       want.is_call,       out_ch.is_call);
        compare_field("called_task",   want.called_task,   out_ch.called_task);
        compare_field("call_argument", want.call_argument, out_ch.call_argument);
        compare_field("last_result",   want.last_result,   out_ch.last_result);
      end
    end
  end

  // ---------------------------------------------------------------------------------------
  // Command side
  // ---------------------------------------------------------------------------------------

  // Offer one command beat after a random gap (none when tx_steady is set); valid stays up until the next call decides
  task automatic send_command(cmd_t op, logic [CHAN_W-1:0] ch, logic [TASK_W-1:0] hdl,
                              logic [ARG_W-1:0] arg);
    int unsigned gap;
    gap = tx_steady ? 0 : $urandom_range(0, MAX_GAP);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid           <= 1'b1;
    in_ch.cmd             <= op;
    in_ch.channel_number  <= ch;
    in_ch.task_handle     <= hdl;
    in_ch.notify_argument <= arg;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    predict_command(op, ch, hdl, arg);
  endtask

  // Stop offering and wait until every owed beat has been taken
  task automatic wait_drained();
    if (in_ch.valid === 1'b1) in_ch.valid <= 1'b0;
    while (owed_results.size() != 0) @(posedge clk);
  endtask

  // Registers are only written with the block idle
  task automatic set_registers(logic [CHAN_W-1:0] lo, logic [CHAN_W-1:0] hi,
                               logic [CHAN_W-1:0] wild);
    logic [CFG_IDX_W-1:0] idx  [3] = '{CFG_LOWEST, CFG_HIGHEST, CFG_WILDCARD};
    logic [CHAN_W-1:0]    vals [3];
    vals = '{lo, hi, wild};
    wait_drained();
    for (int k = 0; k < 3; k++) begin
      cfg_ch.valid <= 1'b1;
      cfg_ch.index <= idx[k];
      cfg_ch.data  <= vals[k];
      @(posedge clk);
      while (cfg_ch.ready !== 1'b1) @(posedge clk);
      case (idx[k])
        CFG_LOWEST:  chan_lo   = vals[k];
        CFG_HIGHEST: chan_hi   = vals[k];
        default:     chan_wild = vals[k];
      endcase
    end
    cfg_ch.valid <= 1'b0;
  endtask

  // Mostly a few channels near the bottom of the range so pairs collide; some edges and noise
  function automatic logic [CHAN_W-1:0] pick_channel();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return chan_lo + CHAN_W'($urandom_range(0, 3));
    if (r < 65) return chan_wild;
    if (r < 75) return chan_hi;
    if (r < 80) return chan_lo - 1'b1;
    if (r < 85) return chan_hi + 1'b1;
    return CHAN_W'($urandom());
  endfunction

  // Small handle pool (null task included) so duplicates and unsubscribes land
  function automatic logic [TASK_W-1:0] pick_handle();
    if ($urandom_range(0, 99) < 70) return TASK_W'($urandom_range(0, 6));
    return TASK_W'($urandom());
  endfunction

  task automatic random_commands(int count);
    int unsigned r;
    cmd_t        op;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(0, 99);
      if (r < 45)      op = CMD_SUB;
      else if (r < 70) op = CMD_UNSUB;
      else if (r < 95) op = CMD_NOTIFY;
      else             op = CMD_CLEAR;
      // flip between idling and back-to-back stretches now and then
      if ($urandom_range(0, 15) == 0) tx_steady = !tx_steady;
      if ($urandom_range(0, 15) == 0) rx_steady = !rx_steady;
      send_command(op, pick_channel(), pick_handle(), $urandom());
    end
  endtask

  // ---------------------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------------------

  // Reset registers: full range, wildcard 255
  task automatic test_directed_defaults();
    send_command(CMD_NOTIFY, 8'd5,   16'h0000, 32'h0000_0000);  // empty table: status only
    send_command(CMD_SUB,    8'd0,   16'hFFFF, 32'h0);
    send_command(CMD_SUB,    8'd255, 16'h0001, 32'h0);
    send_command(CMD_SUB,    8'd0,   16'hFFFF, 32'h0);          // duplicate pair
    send_command(CMD_SUB,    8'd7,   16'h0000, 32'h0);          // null task entry
    send_command(CMD_NOTIFY, 8'd255, 16'h0000, 32'hFFFF_FFFF);  // wildcard, null skipped
    send_command(CMD_SUB,    8'd9,   16'h0005, 32'h0);          // reuses the null entry
    send_command(CMD_NOTIFY, 8'd0,   16'h0000, 32'hA5A5_5A5A);
    send_command(CMD_UNSUB,  8'd9,   16'h0000, 32'h0);          // free entries never match
    send_command(CMD_SUB,    8'd7,   16'h0000, 32'h0);
    send_command(CMD_UNSUB,  8'd7,   16'h0000, 32'h0);          // null entry removed
    send_command(CMD_UNSUB,  8'd3,   16'h0001, 32'h0);          // not found
    send_command(CMD_UNSUB,  8'd255, 16'h0001, 32'h0);          // wildcard unsubscribe
    send_command(CMD_CLEAR,  8'd0,   16'h0000, 32'h0);
    send_command(CMD_NOTIFY, 8'd255, 16'h0000, 32'h1234_5678);
  endtask

  // Narrow range with the wildcard outside it, then an inverted range
  task automatic test_directed_ranges();
    set_registers(8'd10, 8'd20, 8'd200);
    send_command(CMD_SUB,    8'd9,   16'h0002, 32'h0);          // below range
    send_command(CMD_SUB,    8'd21,  16'h0002, 32'h0);          // above range
    send_command(CMD_SUB,    8'd10,  16'h0002, 32'h0);
    send_command(CMD_SUB,    8'd20,  16'h0003, 32'h0);
    send_command(CMD_NOTIFY, 8'd200, 16'h0000, 32'h0F0F_0F0F);  // wildcard rejected by notify
    send_command(CMD_UNSUB,  8'd200, 16'h0002, 32'h0);          // but accepted by unsubscribe
    send_command(CMD_NOTIFY, 8'd20,  16'h0000, 32'hF0F0_F0F0);
    set_registers(8'd255, 8'd0, 8'd0);
    send_command(CMD_SUB,    8'd128, 16'h0004, 32'h0);          // every channel illegal
    send_command(CMD_NOTIFY, 8'd0,   16'h0000, 32'h0);
    send_command(CMD_UNSUB,  8'd0,   16'h0003, 32'h0);
  endtask

  task automatic test_default_range_random();
    set_registers(8'd0, 8'd255, 8'd255);
    random_commands(100);
  endtask

  task automatic test_narrow_range();
    set_registers(8'd40, 8'd47, 8'd44);   // wildcard inside the range
    random_commands(90);
  endtask

  task automatic test_single_channel();
    set_registers(8'd128, 8'd128, 8'd128);
    random_commands(50);
  endtask

  task automatic test_inverted_range();
    set_registers(8'd200, 8'd100, 8'd0);
    random_commands(40);
  endtask

  // Fill every entry, overflow it, then hit a duplicate on the full table
  task automatic test_table_full();
    logic [CHAN_W-1:0] ch;
    logic [CHAN_W-1:0] dup_ch;
    set_registers(8'd0, 8'd255, 8'd0);
    send_command(CMD_CLEAR, 8'd0, 16'h0000, 32'h0);
    dup_ch = '0;
    for (int k = 0; k <= ENTRIES; k++) begin
      ch = CHAN_W'($urandom_range(1, 4));
      if (k == ENTRIES - 1) dup_ch = ch;
      send_command(CMD_SUB, ch, TASK_W'(16'h0100 + k), 32'h0);
    end
    send_command(CMD_SUB, dup_ch, TASK_W'(16'h0100 + ENTRIES - 1), 32'h0);
    send_command(CMD_NOTIFY, 8'd0, 16'h0000, $urandom());       // wildcard: every entry
    random_commands(60);
  endtask

  // Long receiver hold while notifies pile up, with a full drain pause before it
  task automatic test_output_backpressure();
    logic [CHAN_W-1:0] hot;
    set_registers(8'd0, 8'd255, 8'd255);
    hot = CHAN_W'($urandom_range(0, 254));
    send_command(CMD_CLEAR, 8'd0, 16'h0000, 32'h0);
    for (int k = 0; k < 10; k++) send_command(CMD_SUB, hot, TASK_W'(16'h0200 + k), 32'h0);
    wait_drained();
    tx_steady = 1'b1;
    hold_seq <= hold_seq + 1;
    for (int k = 0; k < 12; k++) send_command(CMD_NOTIFY, hot, 16'h0000, $urandom());
    tx_steady = 1'b0;
    random_commands(40);
  endtask

  initial begin : stimulus
    in_ch.valid           <= 1'b0;
    in_ch.cmd             <= CMD_SUB;
    in_ch.channel_number  <= '0;
    in_ch.task_handle     <= '0;
    in_ch.notify_argument <= '0;
    cfg_ch.valid          <= 1'b0;
    cfg_ch.index          <= CFG_LOWEST;
    cfg_ch.data           <= '0;
    rst_n                 <= 1'b0;
    for (int i = 0; i < ENTRIES; i++) drop_slot(i);
    chan_lo   = 8'd0;
    chan_hi   = 8'd255;
    chan_wild = 8'd255;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    test_directed_defaults();
    test_directed_ranges();
    test_default_range_random();
    test_narrow_range();
    test_single_channel();
    test_inverted_range();
    test_table_full();
    test_output_backpressure();

    wait_drained();
    // keep idling to catch stray beats
    repeat (ENTRIES + 8) @(posedge clk);
    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
